[rtl/uartfr_pkg.sv]
// shared types, constants and crc function for the uart frame receiver
package uartfr_pkg;

  localparam int unsigned TEXT_BUFFER_BYTES = 1024;
  localparam int unsigned TextCntW = $clog2(TEXT_BUFFER_BYTES);
  localparam logic [TextCntW-1:0] TextMax = TextCntW'(TEXT_BUFFER_BYTES - 1);

  localparam int unsigned MaxRes = 3;
  localparam int unsigned ResCntW = $clog2(MaxRes + 1);
  localparam int unsigned ResIdxW = $clog2(MaxRes);

  localparam logic [7:0]  LeadByte = 8'h5A;
  localparam logic [7:0]  TextMark = 8'hFE;
  localparam logic [7:0]  TextOpen2 = 8'hF0;
  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [15:0] CrcStart = 16'h0000;

  localparam logic OpByte = 1'b0;
  localparam logic OpTimeout = 1'b1;

  localparam logic [1:0] KindPayload = 2'd0;
  localparam logic [1:0] KindFrameEnd = 2'd1;
  localparam logic [1:0] KindTextChar = 2'd2;
  localparam logic [1:0] KindTextEnd = 2'd3;

  localparam logic [1:0] StatOk = 2'd0;
  localparam logic [1:0] StatCrcErr = 2'd1;
  localparam logic [1:0] StatTimeout = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [7:0] frame_type;
    logic [7:0] frame_length;
    logic [1:0] status;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [ResCntW-1:0]     n;
    result_t [MaxRes-1:0]   res;
  } group_t;

  function automatic result_t make_res(logic [1:0] kind, logic [7:0] data,
                                       logic [7:0] ftype, logic [7:0] flen,
                                       logic [1:0] status);
    result_t r;
    r.kind = kind;
    r.data_byte = data;
    r.frame_type = ftype;
    r.frame_length = flen;
    r.status = status;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CrcPoly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

[rtl/uartfr_in_if.sv]
// receive event channel
interface uartfr_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] rx_byte;

  modport source (output valid, output operation, output rx_byte, input ready);
  modport sink (input valid, input operation, input rx_byte, output ready);
endinterface

[rtl/uartfr_out_if.sv]
// result channel
interface uartfr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic [7:0] frame_type;
  logic [7:0] frame_length;
  logic [1:0] status;
  logic       last;

  modport source (output valid, output kind, output data_byte, output frame_type,
                  output frame_length, output status, output last, input ready);
  modport sink (input valid, input kind, input data_byte, input frame_type,
                input frame_length, input status, input last, output ready);
endinterface

[rtl/uartfr_core.sv]
// frame parser state, crc update and per-event result group
module uartfr_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic                  operation_i,
  input  logic [7:0]            rx_byte_i,
  output uartfr_pkg::group_t    group_o
);

  localparam logic [3:0] PhHunt = 4'd0;
  localparam logic [3:0] PhTextOpen = 4'd1;
  localparam logic [3:0] PhTextBody = 4'd2;
  localparam logic [3:0] PhTextMark = 4'd3;
  localparam logic [3:0] PhType = 4'd4;
  localparam logic [3:0] PhLen = 4'd5;
  localparam logic [3:0] PhPayload = 4'd6;
  localparam logic [3:0] PhCrcHi = 4'd7;
  localparam logic [3:0] PhCrcLo = 4'd8;

  logic [3:0]                       phase_q, phase_d;
  logic [15:0]                      crc_q, crc_d;
  logic [7:0]                       type_q, type_d;
  logic [7:0]                       len_q, len_d;
  logic [7:0]                       pcnt_q, pcnt_d;
  logic [7:0]                       crchi_q, crchi_d;
  logic [uartfr_pkg::TextCntW-1:0]  tcnt_q, tcnt_d;
  logic [uartfr_pkg::ResCntW-1:0]   n;
  uartfr_pkg::result_t [uartfr_pkg::MaxRes-1:0] res;
  logic                             tmo;
  logic [7:0]                       b;

  function automatic logic [uartfr_pkg::ResCntW-1:0] ResOne();
    return uartfr_pkg::ResCntW'(1);
  endfunction

  assign tmo = (operation_i == uartfr_pkg::OpTimeout);
  assign b = rx_byte_i;

  always_comb begin
    phase_d = phase_q;
    crc_d = crc_q;
    type_d = type_q;
    len_d = len_q;
    pcnt_d = pcnt_q;
    crchi_d = crchi_q;
    tcnt_d = tcnt_q;
    n = '0;
    res = '0;
    unique case (phase_q)
      PhHunt: begin
        if (!tmo) begin
          if (b == uartfr_pkg::LeadByte) begin
            crc_d = uartfr_pkg::crc16_byte(uartfr_pkg::CrcStart, b);
            type_d = '0;
            len_d = '0;
            pcnt_d = '0;
            phase_d = PhType;
          end else if (b == uartfr_pkg::TextMark) begin
            phase_d = PhTextOpen;
          end
        end
      end
      PhTextOpen: begin
        if (!tmo && b == uartfr_pkg::TextOpen2) begin
          tcnt_d = '0;
          phase_d = PhTextBody;
        end else begin
          phase_d = PhHunt;
        end
      end
      PhTextBody: begin
        if (tmo) begin
          if (tcnt_d != '0) begin
            res[n] = uartfr_pkg::make_res(uartfr_pkg::KindTextEnd, '0, '0, '0,
                                          uartfr_pkg::StatOk);
            n = n + ResOne();
          end
          tcnt_d = '0;
          phase_d = PhHunt;
        end else if (b == uartfr_pkg::TextMark) begin
          if (tcnt_d >= uartfr_pkg::TextMax) begin
            res[n] = uartfr_pkg::make_res(uartfr_pkg::KindTextEnd, '0, '0, '0,
                                          uartfr_pkg::StatOk);
            n = n + ResOne();
            tcnt_d = '0;
          end
          phase_d = PhTextMark;
        end else begin
          if (tcnt_d >= uartfr_pkg::TextMax) begin
            res[n] = uartfr_pkg::make_res(uartfr_pkg::KindTextEnd, '0, '0, '0,
                                          uartfr_pkg::StatOk);
            n = n + ResOne();
            tcnt_d = '0;
          end
          res[n] = uartfr_pkg::make_res(uartfr_pkg::KindTextChar, b, '0, '0,
                                        uartfr_pkg::StatOk);
          n = n + ResOne();
          tcnt_d = tcnt_d + uartfr_pkg::TextCntW'(1);
        end
      end
      PhTextMark: begin
        if (!tmo && b == uartfr_pkg::TextMark) begin
          if (tcnt_d != '0) begin
            res[n] = uartfr_pkg::make_res(uartfr_pkg::KindTextEnd, '0, '0, '0,
                                          uartfr_pkg::StatOk);
            n = n + ResOne();
          end
          tcnt_d = '0;
          phase_d = PhHunt;
        end else begin
          // pending mark turns out to be a character
          if (tcnt_d >= uartfr_pkg::TextMax) begin
            res[n] = uartfr_pkg::make_res(uartfr_pkg::KindTextEnd, '0, '0, '0,
                                          uartfr_pkg::StatOk);
            n = n + ResOne();
            tcnt_d = '0;
          end
          res[n] = uartfr_pkg::make_res(uartfr_pkg::KindTextChar, uartfr_pkg::TextMark,
                                        '0, '0, uartfr_pkg::StatOk);
          n = n + ResOne();
          tcnt_d = tcnt_d + uartfr_pkg::TextCntW'(1);
          if (tmo) begin
            if (tcnt_d != '0) begin
              res[n] = uartfr_pkg::make_res(uartfr_pkg::KindTextEnd, '0, '0, '0,
                                            uartfr_pkg::StatOk);
              n = n + ResOne();
            end
            tcnt_d = '0;
            phase_d = PhHunt;
          end else begin
            if (tcnt_d >= uartfr_pkg::TextMax) begin
              res[n] = uartfr_pkg::make_res(uartfr_pkg::KindTextEnd, '0, '0, '0,
                                            uartfr_pkg::StatOk);
              n = n + ResOne();
              tcnt_d = '0;
            end
            res[n] = uartfr_pkg::make_res(uartfr_pkg::KindTextChar, b, '0, '0,
                                          uartfr_pkg::StatOk);
            n = n + ResOne();
            tcnt_d = tcnt_d + uartfr_pkg::TextCntW'(1);
            phase_d = PhTextBody;
          end
        end
      end
      PhType, PhLen, PhPayload, PhCrcHi, PhCrcLo: begin
        if (tmo) begin
          res[n] = uartfr_pkg::make_res(uartfr_pkg::KindFrameEnd, '0, type_q, len_q,
                                        uartfr_pkg::StatTimeout);
          n = n + ResOne();
          phase_d = PhHunt;
        end else begin
          case (phase_q)
            PhType: begin
              type_d = b;
              crc_d = uartfr_pkg::crc16_byte(crc_q, b);
              phase_d = PhLen;
            end
            PhLen: begin
              len_d = b;
              crc_d = uartfr_pkg::crc16_byte(crc_q, b);
              pcnt_d = '0;
              phase_d = (b == 8'd0) ? PhCrcHi : PhPayload;
            end
            PhPayload: begin
              res[n] = uartfr_pkg::make_res(uartfr_pkg::KindPayload, b, type_q, len_q,
                                            uartfr_pkg::StatOk);
              n = n + ResOne();
              crc_d = uartfr_pkg::crc16_byte(crc_q, b);
              pcnt_d = pcnt_q + 8'd1;
              if (pcnt_d == len_q) begin
                phase_d = PhCrcHi;
              end
            end
            PhCrcHi: begin
              crchi_d = b;
              phase_d = PhCrcLo;
            end
            default: begin
              res[n] = uartfr_pkg::make_res(uartfr_pkg::KindFrameEnd, '0, type_q, len_q,
                                            ({crchi_q, b} == crc_q) ? uartfr_pkg::StatOk
                                                                    : uartfr_pkg::StatCrcErr);
              n = n + ResOne();
              phase_d = PhHunt;
            end
          endcase
        end
      end
      default: begin
        phase_d = PhHunt;
      end
    endcase
    for (int i = 0; i < uartfr_pkg::MaxRes; i++) begin
      res[i].last = (uartfr_pkg::ResCntW'(i + 1) == n);
    end
  end

  assign group_o.n = n;
  assign group_o.res = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      crc_q <= uartfr_pkg::CrcStart;
      type_q <= '0;
      len_q <= '0;
      pcnt_q <= '0;
      crchi_q <= '0;
      tcnt_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      crc_q <= crc_d;
      type_q <= type_d;
      len_q <= len_d;
      pcnt_q <= pcnt_d;
      crchi_q <= crchi_d;
      tcnt_q <= tcnt_d;
    end
  end

`ifndef SYNTH
  a_phase_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= PhCrcLo)
    else $error("parser phase out of range");
  a_text_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tcnt_q <= uartfr_pkg::TextMax)
    else $error("text chunk counter exceeds chunk size");
  a_payload_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhPayload) |-> (pcnt_q < len_q))
    else $error("payload counter passed frame length");
`endif

endmodule

[rtl/uartfr_outbuf.sv]
// result buffer that drains one result group a beat at a time
module uartfr_outbuf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_req_i,
  input  uartfr_pkg::group_t group_i,
  output logic               load_o,
  uartfr_out_if.source       res_o
);

  uartfr_pkg::result_t [uartfr_pkg::MaxRes-1:0] res_q;
  logic [uartfr_pkg::ResCntW-1:0]               cnt_q, cnt_d;
  logic [uartfr_pkg::ResIdxW-1:0]               idx_q, idx_d;
  logic                                         fire;
  logic                                         can_load;
  uartfr_pkg::result_t                          cur;

  assign fire = res_o.valid && res_o.ready;
  assign can_load = (cnt_q == '0) ||
                    (cnt_q == uartfr_pkg::ResCntW'(1) && res_o.ready);
  assign load_o = load_req_i && can_load;

  always_comb begin
    cnt_d = cnt_q;
    idx_d = idx_q;
    if (load_o) begin
      cnt_d = group_i.n;
      idx_d = '0;
    end else if (fire) begin
      cnt_d = cnt_q - uartfr_pkg::ResCntW'(1);
      idx_d = idx_q + uartfr_pkg::ResIdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_o) begin
      res_q <= group_i.res;
    end
  end

  assign cur = res_q[idx_q];
  assign res_o.valid = (cnt_q != '0);
  assign res_o.kind = cur.kind;
  assign res_o.data_byte = cur.data_byte;
  assign res_o.frame_type = cur.frame_type;
  assign res_o.frame_length = cur.frame_length;
  assign res_o.status = cur.status;
  assign res_o.last = cur.last;

`ifndef SYNTH
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uartfr_pkg::ResCntW'(idx_q) + cnt_q) <= uartfr_pkg::ResCntW'(uartfr_pkg::MaxRes))
    else $error("result buffer read past its group");
  a_last_on_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.last == (cnt_q == uartfr_pkg::ResCntW'(1))))
    else $error("last flag not on final beat of group");
  a_load_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q > uartfr_pkg::ResCntW'(1)) |-> !load_o)
    else $error("new group loaded over pending results");
`endif

endmodule

[rtl/uart_frame_receiver_crc16_unit.sv]
// top level of the uart frame receiver with crc-16 check and text pass-through
// Each receive event (byte or timeout) is registered, then parsed combinationally:
// the parser updates its state and crc and hands a group of zero to three results
// to a three-entry result buffer, which presents them one beat per cycle while the
// sink is ready. A new event is taken only when the buffer is empty or its final
// beat is being taken, so an event is taken every cycle while each yields at most
// one result and the sink is ready; an event with more results holds the parser.
module uart_frame_receiver_crc16_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  uartfr_in_if.sink    rx_i,
  uartfr_out_if.source res_o
);

  logic               in_vld_q;
  logic               in_op_q;
  logic [7:0]         in_byte_q;
  logic               step;
  uartfr_pkg::group_t group;

  assign rx_i.ready = !in_vld_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_vld_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.ready && rx_i.valid) begin
      in_op_q <= rx_i.operation;
      in_byte_q <= rx_i.rx_byte;
    end
  end

  uartfr_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .operation_i (in_op_q),
    .rx_byte_i   (in_byte_q),
    .group_o     (group)
  );

  uartfr_outbuf u_outbuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_req_i (in_vld_q),
    .group_i    (group),
    .load_o     (step),
    .res_o      (res_o)
  );

endmodule
